/* hw/rtl/mbd_pkg.sv */
// shared types, codes and helper functions of the modbus frame decoder
package mbd_pkg;

	localparam int MaxFrameCharsDef = 1024;

	localparam logic [1:0] MODE_RTU   = 2'd0;
	localparam logic [1:0] MODE_ASCII = 2'd1;
	localparam logic [1:0] MODE_TCP   = 2'd2;

	localparam logic [1:0] KIND_ADDR = 2'd0;
	localparam logic [1:0] KIND_FUNC = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;
	localparam logic [1:0] KIND_END  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_CHECKSUM = 3'd2;
	localparam logic [2:0] ST_DELIM    = 3'd3;
	localparam logic [2:0] ST_LENGTH   = 3'd4;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic [15:0] crc;
		logic [7:0]  lrc;
		logic [7:0]  dl0;
		logic [7:0]  dl1;
		logic [3:0]  hi_nib;
		logic        nib_phase;
		logic [15:0] hdr_len;
		logic [2:0]  fault;
	} frame_st_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] value;
		logic       last;
		logic [2:0] status;
	} result_t;

	localparam frame_st_t FRAME_CLEAR = '{
		crc: CRC_INIT, lrc: 8'h00, dl0: 8'h00, dl1: 8'h00, hi_nib: 4'h0,
		nib_phase: 1'b0, hdr_len: 16'h0000, fault: ST_OK
	};

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// bit 4 set when the character is not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = {1'b0, 4'(c - 8'h61 + 8'd10)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = {1'b0, 4'(c - 8'h41 + 8'd10)};
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

endpackage

/* hw/rtl/mbd_decode.sv */
// per-byte decode: next frame state and the optional result of one byte
module mbd_decode import mbd_pkg::*; #(
	parameter int MaxFrameChars = MaxFrameCharsDef,
	parameter int PosW = $clog2(MaxFrameChars)
) (
	input  logic [1:0]      mode,
	input  logic [PosW-1:0] pos,
	input  frame_st_t       cur,
	input  logic [7:0]      data_byte,
	input  logic            frame_last,
	output logic [PosW-1:0] pos_next,
	output frame_st_t       nxt,
	output result_t         res
);

	logic [PosW-1:0] rtu_idx;
	logic [PosW-1:0] asc_idx;
	logic [PosW-1:0] tcp_idx;
	logic [15:0]     crc_new;
	logic [4:0]      hex;
	logic [17:0]     pos_plus1;
	logic [17:0]     len_need;

	function automatic logic [1:0] kind_at(input logic [PosW-1:0] idx);
		logic [1:0] k;
		if (idx == '0) begin
			k = KIND_ADDR;
		end else if (idx == PosW'(1)) begin
			k = KIND_FUNC;
		end else begin
			k = KIND_DATA;
		end
		return k;
	endfunction

	assign rtu_idx   = pos - PosW'(2);
	assign asc_idx   = (pos - PosW'(5)) >> 1;
	assign tcp_idx   = pos - PosW'(6);
	assign crc_new   = crc_feed(cur.crc, cur.dl1);
	assign hex       = hex_value(cur.dl0);
	assign pos_plus1 = 18'(pos) + 18'd1;
	assign len_need  = 18'(cur.hdr_len) + 18'd6;

	always_comb begin
		nxt = cur;
		res = '0;
		case (mode)
			MODE_RTU: begin
				if (pos >= PosW'(2)) begin
					nxt.crc   = crc_new;
					res.valid = 1'b1;
					res.kind  = kind_at(rtu_idx);
					res.value = cur.dl1;
					res.last  = frame_last;
					if (frame_last) begin
						if (pos < PosW'(3)) begin
							res.status = ST_SHORT;
						end else if (crc_new != {data_byte, cur.dl0}) begin
							res.status = ST_CHECKSUM;
						end
					end
				end else if (frame_last) begin
					res = '{valid: 1'b1, kind: KIND_END, value: 8'h00, last: 1'b1,
						status: ST_SHORT};
				end
				nxt.dl1 = cur.dl0;
				nxt.dl0 = data_byte;
			end
			MODE_ASCII: begin
				if (frame_last) begin
					res.valid = 1'b1;
					res.kind  = KIND_END;
					res.last  = 1'b1;
					if (cur.fault != ST_OK) begin
						res.status = cur.fault;
					end else if (pos < PosW'(2) || cur.dl0 != CHAR_CR || data_byte != CHAR_LF) begin
						res.status = ST_DELIM;
					end else if (cur.nib_phase) begin
						res.status = ST_DELIM;
					end else if (pos < PosW'(8)) begin
						res.status = ST_SHORT;
					end else if ((8'h00 - cur.lrc) != cur.dl1) begin
						res.status = ST_CHECKSUM;
					end
				end else if (pos == '0) begin
					if (data_byte != CHAR_COLON) begin
						nxt.fault = ST_DELIM;
					end
				end else if (pos >= PosW'(2) && cur.fault == ST_OK) begin
					if (hex[4]) begin
						nxt.fault = ST_DELIM;
					end else if (!cur.nib_phase) begin
						nxt.hi_nib    = hex[3:0];
						nxt.nib_phase = 1'b1;
					end else begin
						nxt.nib_phase = 1'b0;
						if (pos >= PosW'(5)) begin
							res.valid = 1'b1;
							res.kind  = kind_at(asc_idx);
							res.value = cur.dl1;
							nxt.lrc   = cur.lrc + cur.dl1;
						end
						nxt.dl1 = {cur.hi_nib, hex[3:0]};
					end
				end
				nxt.dl0 = data_byte;
			end
			default: begin
				if (pos == PosW'(4)) begin
					nxt.hdr_len = {data_byte, 8'h00};
				end else if (pos == PosW'(5)) begin
					nxt.hdr_len = {cur.hdr_len[15:8], data_byte};
				end
				if (pos >= PosW'(6)) begin
					res.valid = 1'b1;
					res.kind  = kind_at(tcp_idx);
					res.value = data_byte;
					res.last  = frame_last;
					if (frame_last) begin
						if (pos < PosW'(7)) begin
							res.status = ST_SHORT;
						end else if (pos_plus1 < len_need) begin
							res.status = ST_LENGTH;
						end
					end
				end else if (frame_last) begin
					res = '{valid: 1'b1, kind: KIND_END, value: 8'h00, last: 1'b1,
						status: ST_SHORT};
				end
			end
		endcase
		if (frame_last) begin
			nxt      = FRAME_CLEAR;
			pos_next = '0;
		end else if (pos < PosW'(MaxFrameChars - 1)) begin
			pos_next = pos + PosW'(1);
		end else begin
			pos_next = pos;
		end
	end

endmodule

/* hw/rtl/modbus_frame_decoder.sv */
// top level of the modbus frame decoder: input stage, frame state and result register
//
// Decodes one delimited Modbus frame (RTU, ASCII or TCP) byte by byte.
// s_axis: one raw byte per transaction in tdata, tlast on the final byte of the frame.
// m_axis: decoded items; tuser is the item kind (address, function, payload,
//   end status only), tdata carries the byte value and the frame status,
//   tlast marks the last item of the frame with a valid status.
// cfg_we/cfg_wdata write protocol_mode (0 RTU, 1 ASCII, 2 TCP, 3 acts as TCP);
//   a write also clears the frame state and must be done while the block is idle.
// Throughput: one byte per cycle while m_axis is not stalled, set by the combinational
//   CRC update and hex decode between the input register and the result register.
// A result passes through the input register and then the result register onto m_axis;
//   bytes that are held back (RTU checksum, ASCII hex pairs and LRC, TCP header) give
//   no item.
// A stall on m_axis holds the result register; the input register fills and then
//   s_axis_tready drops until the result is taken.
// Reset clears both stages, the frame state and selects RTU mode.
module modbus_frame_decoder import mbd_pkg::*; #(
	parameter int MaxFrameChars = MaxFrameCharsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,      // protocol_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tlast,   // frame_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // item_value [7:0], frame_status [10:8], zero pad
	output logic [1:0]  m_axis_tuser,   // item_kind
	output logic        m_axis_tlast    // frame_end
);

	localparam int PosW = $clog2(MaxFrameChars);

	logic [1:0]      mode_q;
	logic [PosW-1:0] pos_q;
	frame_st_t       st_q;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            last_s1;
	result_t         out_q;
	logic            advance;
	logic [PosW-1:0] pos_next;
	frame_st_t       st_next;
	result_t         res;

	assign advance       = valid_s1 && (!out_q.valid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	mbd_decode #(
		.MaxFrameChars(MaxFrameChars),
		.PosW(PosW)
	) u_decode (
		.mode(mode_q),
		.pos(pos_q),
		.cur(st_q),
		.data_byte(byte_s1),
		.frame_last(last_s1),
		.pos_next(pos_next),
		.nxt(st_next),
		.res(res)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// frame state and mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RTU;
			pos_q  <= '0;
			st_q   <= FRAME_CLEAR;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
			pos_q  <= '0;
			st_q   <= FRAME_CLEAR;
		end else if (advance) begin
			pos_q <= pos_next;
			st_q  <= st_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance) begin
			out_q <= res;
		end else if (m_axis_tready) begin
			out_q.valid <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_q.valid;
	assign m_axis_tdata  = {5'b0, out_q.status, out_q.value};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last;

`ifndef ASSERT_OFF
	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_q.valid && !out_q.last |-> out_q.status == ST_OK)
		else $error("nonzero status on an item that does not end the frame");

	a_end_item_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_q.valid && out_q.kind == KIND_END |-> out_q.last && out_q.value == 8'h00)
		else $error("end status item without frame end or with a value");

	a_cfg_clears_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> pos_q == '0 && st_q == FRAME_CLEAR)
		else $error("frame state not cleared after a mode write");

	a_pos_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosW'(MaxFrameChars - 1))
		else $error("byte position beyond its saturation value");

	a_frame_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 && !cfg_we |=> pos_q == '0)
		else $error("byte position not reset after the last byte of a frame");
`endif

endmodule

/* test/modbus_frame_checker.sv */
`timescale 1ns / 1ps
// decoding model and result checker of the modbus frame decoder testbench
package modbus_tb_pkg;
	import mbd_pkg::*;

	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction
endpackage

module modbus_frame_checker import mbd_pkg::*, modbus_tb_pkg::*; #(
	parameter int MaxFrameChars = MaxFrameCharsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       fin;
		logic [2:0] status;
	} decoded_t;

	decoded_t expected_items[$];

	logic [1:0]  mode;
	int          pos;
	logic [15:0] crc_acc;
	logic [7:0]  lrc;
	logic [7:0]  hold0;
	logic [7:0]  hold1;
	logic [3:0]  hi_nib;
	logic        nib_odd;
	logic [15:0] hdr_len;
	logic [2:0]  fault;

	function automatic logic [1:0] kind_for(input int idx);
		if (idx == 0) begin
			return KIND_ADDR;
		end else if (idx == 1) begin
			return KIND_FUNC;
		end
		return KIND_DATA;
	endfunction

	function automatic int hex_nibble(input logic [7:0] ch);
		if (ch >= "0" && ch <= "9") begin
			return int'(ch - "0");
		end else if (ch >= "a" && ch <= "f") begin
			return int'(ch - "a") + 10;
		end else if (ch >= "A" && ch <= "F") begin
			return int'(ch - "A") + 10;
		end
		return -1;
	endfunction

	task automatic clear_frame();
		pos = 0;
		crc_acc = CRC_INIT;
		lrc = 8'h00;
		hold0 = 8'h00;
		hold1 = 8'h00;
		hi_nib = 4'h0;
		nib_odd = 1'b0;
		hdr_len = 16'h0000;
		fault = ST_OK;
	endtask

	task automatic expect_item(input logic [1:0] kind, input logic [7:0] value, input logic fin,
			input logic [2:0] status);
		expected_items.push_back(decoded_t'{kind, value, fin, status});
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic fin);
		int          p;
		int          v;
		int          q;
		logic [7:0]  held;
		logic [7:0]  full;
		logic [7:0]  want_lrc;
		logic [15:0] got;
		logic [2:0]  st;
		p = pos;
		if (mode == MODE_RTU) begin
			if (p >= 2) begin
				held = hold1;
				crc_acc = crc16_next(crc_acc, held);
				st = ST_OK;
				if (fin) begin
					got = {b, hold0};
					st = (p < 3) ? ST_SHORT : ((crc_acc == got) ? ST_OK : ST_CHECKSUM);
				end
				expect_item(kind_for(p - 2), held, fin, st);
			end else if (fin) begin
				expect_item(KIND_END, 8'h00, 1'b1, ST_SHORT);
			end
			hold1 = hold0;
			hold0 = b;
		end else if (mode == MODE_ASCII) begin
			if (fin) begin
				want_lrc = 8'h00 - lrc;
				if (fault != ST_OK) begin
					st = fault;
				end else if (p < 2 || hold0 != CHAR_CR || b != CHAR_LF) begin
					st = ST_DELIM;
				end else if (nib_odd) begin
					st = ST_DELIM;
				end else if (p < 8) begin
					st = ST_SHORT;
				end else begin
					st = (want_lrc == hold1) ? ST_OK : ST_CHECKSUM;
				end
				expect_item(KIND_END, 8'h00, 1'b1, st);
			end else if (p == 0) begin
				if (b != CHAR_COLON) begin
					fault = ST_DELIM;
				end
			end else if (p >= 2 && fault == ST_OK) begin
				v = hex_nibble(hold0);
				if (v < 0) begin
					fault = ST_DELIM;
				end else if (!nib_odd) begin
					hi_nib = v[3:0];
					nib_odd = 1'b1;
				end else begin
					q = p - 1;
					full = {hi_nib, v[3:0]};
					nib_odd = 1'b0;
					if (q >= 4) begin
						expect_item(kind_for((q - 4) / 2), hold1, 1'b0, ST_OK);
						lrc = lrc + hold1;
					end
					hold1 = full;
				end
			end
			hold0 = b;
		end else begin
			// tcp, and the unused mode value behaves the same
			if (p == 4) begin
				hdr_len = {b, 8'h00};
			end else if (p == 5) begin
				hdr_len[7:0] = b;
			end
			if (p >= 6) begin
				st = ST_OK;
				if (fin) begin
					st = (p < 7) ? ST_SHORT : ((p + 1 < 6 + int'(hdr_len)) ? ST_LENGTH : ST_OK);
				end
				expect_item(kind_for(p - 6), b, fin, st);
			end else if (fin) begin
				expect_item(KIND_END, 8'h00, 1'b1, ST_SHORT);
			end
		end
		if (fin) begin
			clear_frame();
		end else if (pos < MaxFrameChars - 1) begin
			pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		decoded_t    want;
		logic [15:0] want_data;
		if (!arst_n) begin
			mode = MODE_RTU;
			clear_frame();
			expected_items.delete();
			errors = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_items.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected transaction: kind %0d data %04h end %0b",
							m_axis_tuser, m_axis_tdata, m_axis_tlast);
					end
				end else begin
					want = expected_items.pop_front();
					want_data = {5'b00000, want.status, want.value};
					if (m_axis_tuser !== want.kind || m_axis_tdata !== want_data ||
							m_axis_tlast !== want.fin) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: expected kind %0d data %04h end %0b, got kind %0d data %04h end %0b",
								want.kind, want_data, want.fin,
								m_axis_tuser, m_axis_tdata, m_axis_tlast);
						end
					end
				end
			end
			if (cfg_we) begin
				mode = cfg_wdata;
				clear_frame();
			end
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, s_axis_tlast);
			end
		end
		pending = expected_items.size();
	end

endmodule

/* test/tb_modbus_frame_decoder.sv */
`timescale 1ns / 1ps
// stimulus, clocking and verdict of the modbus frame decoder testbench
module tb_modbus_frame_decoder;
	import mbd_pkg::*;
	import modbus_tb_pkg::*;

	localparam logic [1:0] MODE_TCP_ALT = 2'd3;
	localparam int IdleLimit = 4000;
	localparam int LongHold = 300;
	localparam int PhaseBytes = 50;
	localparam int Phases = 8;

	typedef enum int {FLAW_NONE, FLAW_START, FLAW_HEX, FLAW_ODD, FLAW_END, FLAW_SUM} ascii_flaw_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_wdata = MODE_RTU;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int          errors;
	int          pending;
	int          idle_cycles = 0;
	int          sent_bytes = 0;
	bit          gaps_on = 1'b1;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;
	logic [7:0]  frame_q[$];
	logic [1:0]  phase_modes [0:Phases-1] = '{MODE_TCP, MODE_RTU, MODE_ASCII, MODE_TCP_ALT,
		MODE_ASCII, MODE_RTU, MODE_TCP, MODE_ASCII};

	always #4 clk = ~clk;

	modbus_frame_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	modbus_frame_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.errors        (errors),
		.pending       (pending)
	);

	// cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IdleLimit) begin
			$display("[modbus_frame_decoder] ERROR");
			$finish;
		end
	end

	// receiver: random stall bursts and one long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LongHold) @(negedge clk);
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	function automatic logic [7:0] body_byte(input int fill);
		if (fill < 0) begin
			return 8'($urandom_range(0, 255));
		end
		return fill[7:0];
	endfunction

	task automatic put_byte(input logic [7:0] b, input logic fin);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= fin;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent_bytes++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame_q.size(); i++) begin
			put_byte(frame_q[i], i == frame_q.size() - 1);
		end
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_mode(input logic [1:0] m);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic build_noise(input int n);
		int i;
		frame_q.delete();
		for (i = 0; i < n; i++) begin
			frame_q.push_back(body_byte(-1));
		end
	endtask

	task automatic build_rtu(input int n_body, input bit bad_crc, input int fill);
		logic [15:0] c;
		logic [7:0]  b;
		int          i;
		frame_q.delete();
		c = CRC_INIT;
		for (i = 0; i < n_body; i++) begin
			b = body_byte(fill);
			frame_q.push_back(b);
			c = crc16_next(c, b);
		end
		if (bad_crc) begin
			c = c ^ 16'($urandom_range(1, 65535));
		end
		frame_q.push_back(c[7:0]);
		frame_q.push_back(c[15:8]);
	endtask

	task automatic build_ascii(input int n_body, input ascii_flaw_t flaw, input int fill);
		logic [7:0] body[$];
		logic [7:0] sum;
		logic [7:0] c;
		logic [3:0] nib;
		int         i;
		int         k;
		int         idx;
		sum = 8'h00;
		for (i = 0; i < n_body; i++) begin
			body.push_back(body_byte(fill));
			sum = sum + body[i];
		end
		body.push_back(8'h00 - sum);
		if (flaw == FLAW_SUM) begin
			body[n_body] = body[n_body] ^ 8'($urandom_range(1, 255));
		end
		frame_q.delete();
		frame_q.push_back(CHAR_COLON);
		for (i = 0; i < body.size(); i++) begin
			for (k = 1; k >= 0; k--) begin
				nib = body[i][4*k +: 4];
				if (nib < 10) begin
					c = "0" + nib;
				end else if ($urandom_range(0, 1) == 1) begin
					c = "a" + nib - 8'd10;
				end else begin
					c = "A" + nib - 8'd10;
				end
				frame_q.push_back(c);
			end
		end
		frame_q.push_back(CHAR_CR);
		frame_q.push_back(CHAR_LF);
		case (flaw)
			FLAW_START: begin
				do c = 8'($urandom_range(0, 255)); while (c == CHAR_COLON);
				frame_q[0] = c;
			end
			FLAW_HEX: begin
				idx = $urandom_range(1, frame_q.size() - 3);
				do c = 8'($urandom_range(0, 255));
				while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
					(c >= "A" && c <= "F"));
				frame_q[idx] = c;
			end
			FLAW_ODD: begin
				frame_q.delete($urandom_range(1, frame_q.size() - 3));
			end
			FLAW_END: begin
				idx = frame_q.size() - 1 - $urandom_range(0, 1);
				frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
			end
			default: begin
			end
		endcase
	endtask

	task automatic build_tcp(input int n_after, input int len_field, input int fill);
		logic [15:0] len;
		int          i;
		len = len_field[15:0];
		frame_q.delete();
		for (i = 0; i < 4; i++) begin
			frame_q.push_back(body_byte(-1));
		end
		frame_q.push_back(len[15:8]);
		frame_q.push_back(len[7:0]);
		for (i = 0; i < n_after; i++) begin
			frame_q.push_back(body_byte(fill));
		end
	endtask

	// mostly well-formed frames, some broken ones and some noise
	task automatic random_frame(input logic [1:0] m);
		int r;
		int n;
		r = $urandom_range(0, 9);
		n = $urandom_range(2, 12);
		if (r == 9) begin
			build_noise($urandom_range(1, 8));
		end else if (m == MODE_RTU) begin
			if (r < 7) begin
				build_rtu(n, 1'b0, -1);
			end else if (r == 7) begin
				build_rtu($urandom_range(0, 1), 1'b0, -1);
			end else begin
				build_rtu(n, 1'b1, -1);
			end
		end else if (m == MODE_ASCII) begin
			if (r < 7) begin
				build_ascii(n, FLAW_NONE, -1);
			end else begin
				build_ascii($urandom_range(0, 8), ascii_flaw_t'($urandom_range(1, 5)), -1);
			end
		end else begin
			if (r < 7) begin
				build_tcp(n, n, -1);
			end else if (r == 7) begin
				build_tcp($urandom_range(0, 12), $urandom_range(0, 20), -1);
			end else begin
				build_tcp($urandom_range(0, 12), $urandom_range(0, 65535), -1);
			end
		end
		send_frame();
	endtask

	initial begin
		int p;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// rtu after reset: short frames, extreme bytes, bad checksum
		build_noise(1);
		send_frame();
		build_rtu(0, 1'b0, -1);
		send_frame();
		build_rtu(1, 1'b0, -1);
		send_frame();
		build_rtu(2, 1'b0, 8'h00);
		send_frame();
		build_rtu(4, 1'b0, 8'hFF);
		send_frame();
		build_rtu(3, 1'b1, -1);
		send_frame();

		set_mode(MODE_ASCII);
		build_ascii(3, FLAW_NONE, 8'h00);
		send_frame();
		build_ascii(3, FLAW_NONE, 8'hFF);
		send_frame();
		build_ascii(0, FLAW_NONE, -1);
		send_frame();
		build_ascii(1, FLAW_NONE, -1);
		send_frame();
		build_ascii(2, FLAW_START, -1);
		send_frame();
		build_ascii(2, FLAW_HEX, -1);
		send_frame();
		build_ascii(2, FLAW_ODD, -1);
		send_frame();
		build_ascii(2, FLAW_END, -1);
		send_frame();
		build_ascii(2, FLAW_SUM, -1);
		send_frame();
		build_noise(1);
		send_frame();

		set_mode(MODE_TCP);
		build_noise(3);
		send_frame();
		build_tcp(0, 0, -1);
		send_frame();
		build_tcp(1, 1, -1);
		send_frame();
		build_tcp(2, 2, 8'h00);
		send_frame();
		build_tcp(2, 5, 8'hFF);
		send_frame();
		build_tcp(4, 1, -1);
		send_frame();
		build_tcp(3, 16'hFFFF, -1);
		send_frame();

		set_mode(MODE_TCP_ALT);
		build_tcp(3, 3, -1);
		send_frame();
		build_tcp(3, 9, -1);
		send_frame();

		set_mode(MODE_RTU);
		build_rtu(5, 1'b0, -1);
		send_frame();

		for (p = 0; p < Phases; p++) begin
			set_mode(phase_modes[p]);
			gaps_on = (p < Phases - 2);
			if (p == 0) begin
				hold_req = 1'b1;
			end
			sent_bytes = 0;
			while (sent_bytes < PhaseBytes) begin
				random_frame(phase_modes[p]);
			end
		end

		settle();
		if (errors == 0) begin
			$display("[modbus_frame_decoder] OK");
		end else begin
			$display("[modbus_frame_decoder] ERROR");
		end
		$finish;
	end

endmodule
